// ----- src/vmf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmf_pkg
// Shared types, constants and the CRC step for the drive command framer.
// ----------------------------------------------------------------------------
package vmf_pkg;

    // APB register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_MIN_RPM        = 2'd1;
    localparam logic [1:0] REG_MAX_RPM        = 2'd2;

    // Register reset values
    localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'h01;
    localparam logic [15:0] MIN_RPM_RST        = 16'd0;
    localparam logic [15:0] MAX_RPM_RST        = 16'd24000;

    // Command opcodes
    localparam logic [1:0] OP_RUN_MODE = 2'd0;
    localparam logic [1:0] OP_SPEED    = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;

    // Run modes and the codes sent for them
    localparam logic [1:0] RM_FORWARD = 2'd1;
    localparam logic [1:0] RM_REVERSE = 2'd2;
    localparam logic [7:0] RUN_CODE_FORWARD = 8'h01;
    localparam logic [7:0] RUN_CODE_REVERSE = 8'h11;
    localparam logic [7:0] RUN_CODE_STOP    = 8'h08;

    // Function and length bytes
    localparam logic [7:0] FUNC_RUN_MODE = 8'h03;
    localparam logic [7:0] FUNC_SPEED    = 8'h05;
    localparam logic [7:0] FUNC_READ     = 8'h04;
    localparam logic [7:0] LEN_RUN_MODE  = 8'h01;
    localparam logic [7:0] LEN_SPEED     = 8'h02;
    localparam logic [7:0] LEN_READ      = 8'h03;

    // Index of the last body byte of each frame
    localparam logic [2:0] LAST_IDX_RUN_MODE = 3'd3;
    localparam logic [2:0] LAST_IDX_SPEED    = 3'd4;
    localparam logic [2:0] LAST_IDX_READ     = 3'd5;

    // CRC-16, reflected
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Reciprocals: x/100 = (x*DIV100_MUL)>>31 for x < 2^24,
    //              y/3   = (y*DIV3_MUL)>>20   for y < 2^19
    localparam logic [24:0] DIV100_MUL = 25'd21474837;
    localparam logic [18:0] DIV3_MUL   = 19'd349526;

    // Frame queue depth
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        FK_RUN_MODE,
        FK_SPEED,
        FK_READ
    } frame_kind_t;

    // One frame waiting to be sent
    typedef struct packed {
        frame_kind_t kind;
        logic [7:0]  addr;
        logic [7:0]  data3;
        logic [7:0]  data4;
    } desc_t;

    // Configuration registers as seen by the front end
    typedef struct packed {
        logic [7:0]  device_address;
        logic [15:0] min_rpm;
        logic [15:0] max_rpm;
    } cfg_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_CLAMP,
        F_FREQ,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_BODY,
        B_CRC_LO,
        B_CRC_HI
    } back_state_t;

    // One byte into the CRC, eight shift steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- src/vfd_modbus_command_framer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfd_modbus_command_framer
// Turns spindle commands into serial drive frames with a CRC-16 trailer.
// ----------------------------------------------------------------------------
// A run mode command yields a 6-byte frame, a read command an 8-byte frame,
// and a speed command a 7-byte frame, or nothing when the clamped speed is
// the one last sent; opcode 3 is dropped. Frame bytes leave one per cycle
// while out_stall is low, and the back end fetches each frame from the queue
// in its idle state before the first byte. The front end takes a run mode or
// read command straight to its push state, and a speed command through its
// steps (multiply on acceptance, then reciprocal divide by 100, clamp,
// frequency and push), and then parks it in a queue of QueueDepth frames, so
// it keeps taking items while the back end is still sending, until it is full.
// Write min_rpm, max_rpm and device_address only while no frame is pending.
module vfd_modbus_command_framer #(
    parameter int QueueDepth = vmf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vmf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [vmf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [vmf_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    // Command input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [1:0]                    run_mode,
    input  logic [15:0]                   speed_rpm,
    input  logic [7:0]                    override_pct,
    input  logic [2:0]                    status_reg,
    // Frame byte output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    frame_byte,
    output logic                          last_byte
);
    import vmf_pkg::*;

    logic [7:0]  device_address_reg;
    logic [15:0] min_rpm_reg;
    logic [15:0] max_rpm_reg;
    logic        cfg_write;
    cfg_t        cfg;

    logic        push;
    desc_t       push_desc;
    logic        full;
    logic        pop;
    desc_t       pop_desc;
    logic        empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= DEVICE_ADDRESS_RST;
            min_rpm_reg        <= MIN_RPM_RST;
            max_rpm_reg        <= MAX_RPM_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_DEVICE_ADDRESS: device_address_reg <= pwdata[7:0];
                REG_MIN_RPM:        min_rpm_reg        <= pwdata[15:0];
                REG_MAX_RPM:        max_rpm_reg        <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[3:2])
            REG_DEVICE_ADDRESS: prdata = {24'h000000, device_address_reg};
            REG_MIN_RPM:        prdata = {16'h0000, min_rpm_reg};
            REG_MAX_RPM:        prdata = {16'h0000, max_rpm_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.device_address = device_address_reg;
    assign cfg.min_rpm        = min_rpm_reg;
    assign cfg.max_rpm        = max_rpm_reg;

    vmf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .run_mode     (run_mode),
        .speed_rpm    (speed_rpm),
        .override_pct (override_pct),
        .status_reg   (status_reg),
        .push         (push),
        .push_desc    (push_desc),
        .full         (full)
    );

    vmf_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (full),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .empty     (empty)
    );

    vmf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .pop_desc   (pop_desc),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

endmodule

// ----- src/vmf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmf_front
// Accepts commands, classifies them and builds frame descriptors. Speed
// commands are scaled, clamped and converted to frequency here.
// ----------------------------------------------------------------------------
module vmf_front (
    input  logic           clk,
    input  logic           rst_n,
    input  vmf_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     opcode,
    input  logic [1:0]     run_mode,
    input  logic [15:0]    speed_rpm,
    input  logic [7:0]     override_pct,
    input  logic [2:0]     status_reg,
    output logic           push,
    output vmf_pkg::desc_t push_desc,
    input  logic           full
);
    import vmf_pkg::*;

    front_state_t state_reg, state_next;
    logic [15:0]  last_sent_reg, last_sent_next;
    logic [23:0]  prod_reg, prod_next;
    logic [17:0]  quot_reg, quot_next;
    logic [18:0]  y_reg, y_next;
    desc_t        desc_reg, desc_next;

    logic         accept;
    logic [48:0]  div_prod;
    logic [37:0]  freq_prod;
    logic [15:0]  rpm_clamped;
    logic         rpm_same;
    logic [7:0]   run_code;

    assign accept = in_valid && (state_reg == F_IDLE);

    // Speed datapath pieces
    always_comb
    begin
        div_prod  = 49'(prod_reg) * 49'(DIV100_MUL);
        freq_prod = 38'(y_reg) * 38'(DIV3_MUL);

        if ((cfg.min_rpm >= cfg.max_rpm) || (quot_reg >= {2'b00, cfg.max_rpm}))
            rpm_clamped = cfg.max_rpm;
        else if ((quot_reg != 18'd0) && (quot_reg <= {2'b00, cfg.min_rpm}))
            rpm_clamped = cfg.min_rpm;
        else
            rpm_clamped = quot_reg[15:0];
        rpm_same = (rpm_clamped == last_sent_reg);

        case (run_mode)
            RM_FORWARD: run_code = RUN_CODE_FORWARD;
            RM_REVERSE: run_code = RUN_CODE_REVERSE;
            default:    run_code = RUN_CODE_STOP;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    case (opcode)
                        OP_RUN_MODE: state_next = F_PUSH;
                        OP_SPEED:    state_next = F_DIV;
                        OP_READ:     state_next = F_PUSH;
                        default:     state_next = F_IDLE;
                    endcase
                end
            end
            F_DIV:   state_next = F_CLAMP;
            F_CLAMP: state_next = rpm_same ? F_IDLE : F_FREQ;
            F_FREQ:  state_next = F_PUSH;
            F_PUSH:  state_next = full ? F_PUSH : F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        in_stall       = (state_reg != F_IDLE);
        push           = (state_reg == F_PUSH) && !full;
        push_desc      = desc_reg;
        desc_next      = desc_reg;
        prod_next      = prod_reg;
        quot_next      = quot_reg;
        y_next         = y_reg;
        last_sent_next = last_sent_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_RUN_MODE:
                        begin
                            desc_next.kind  = FK_RUN_MODE;
                            desc_next.addr  = cfg.device_address;
                            desc_next.data3 = run_code;
                            desc_next.data4 = 8'h00;
                        end
                        OP_SPEED:
                        begin
                            prod_next = {8'h00, speed_rpm} * {16'h0000, override_pct};
                        end
                        OP_READ:
                        begin
                            desc_next.kind  = FK_READ;
                            desc_next.addr  = cfg.device_address;
                            desc_next.data3 = {5'b00000, status_reg};
                            desc_next.data4 = 8'h00;
                        end
                        default: ;
                    endcase
                end
            end
            F_DIV:
            begin
                quot_next = div_prod[48:31];
            end
            F_CLAMP:
            begin
                if (!rpm_same)
                begin
                    last_sent_next = rpm_clamped;
                    // rpm*100/60 == rpm*5/3
                    y_next = {1'b0, rpm_clamped, 2'b00} + {3'b000, rpm_clamped};
                end
            end
            F_FREQ:
            begin
                desc_next.kind  = FK_SPEED;
                desc_next.addr  = cfg.device_address;
                desc_next.data3 = freq_prod[35:28];
                desc_next.data4 = freq_prod[27:20];
            end
            F_PUSH: ;
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            last_sent_reg <= 16'd0;
        end
        else
        begin
            state_reg     <= state_next;
            last_sent_reg <= last_sent_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        y_reg    <= y_next;
        desc_reg <= desc_next;
    end

    a_last_sent_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_CLAMP && !rpm_same) |=> (last_sent_reg == $past(rpm_clamped)))
        else $error("last sent speed not updated after a new speed");

    a_unchanged_speed_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_CLAMP && rpm_same) |=> (state_reg == F_IDLE))
        else $error("unchanged speed did not drop the command");

endmodule

// ----- src/vmf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmf_queue
// Small FIFO of frame descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module vmf_queue #(
    parameter int Depth = vmf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vmf_pkg::desc_t push_desc,
    output logic           full,
    input  logic           pop,
    output vmf_pkg::desc_t pop_desc,
    output logic           empty
);
    import vmf_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    desc_t            entry_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    assign full     = (count_reg == CntW'(Depth));
    assign empty    = (count_reg == '0);
    assign pop_desc = entry_reg[rd_ptr_reg];

    // Pointer and count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full frame queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty frame queue");

endmodule

// ----- src/vmf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmf_back
// Takes descriptors from the queue and sends each frame one byte per cycle
// when not stalled, runs the CRC over the body and appends it low byte first.
// ----------------------------------------------------------------------------
module vmf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  vmf_pkg::desc_t pop_desc,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     frame_byte,
    output logic           last_byte
);
    import vmf_pkg::*;

    back_state_t state_reg, state_next;
    desc_t       desc_reg;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  frame_byte_reg, frame_byte_next;
    logic        last_byte_reg, last_byte_next;

    logic        load;
    logic [7:0]  body_byte;
    logic [7:0]  func_byte;
    logic [7:0]  len_byte;
    logic [2:0]  last_idx;

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign last_byte  = last_byte_reg;

    // Per-kind frame bytes
    always_comb
    begin
        case (desc_reg.kind)
            FK_RUN_MODE:
            begin
                func_byte = FUNC_RUN_MODE;
                len_byte  = LEN_RUN_MODE;
                last_idx  = LAST_IDX_RUN_MODE;
            end
            FK_SPEED:
            begin
                func_byte = FUNC_SPEED;
                len_byte  = LEN_SPEED;
                last_idx  = LAST_IDX_SPEED;
            end
            default:
            begin
                func_byte = FUNC_READ;
                len_byte  = LEN_READ;
                last_idx  = LAST_IDX_READ;
            end
        endcase

        case (idx_reg)
            3'd0:    body_byte = desc_reg.addr;
            3'd1:    body_byte = func_byte;
            3'd2:    body_byte = len_byte;
            3'd3:    body_byte = desc_reg.data3;
            3'd4:    body_byte = desc_reg.data4;
            default: body_byte = 8'h00;
        endcase
    end

    assign load = (state_reg != B_IDLE) && (!out_valid_reg || !out_stall);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:   state_next = empty ? B_IDLE : B_BODY;
            B_BODY:   state_next = (load && idx_reg == last_idx) ? B_CRC_LO : B_BODY;
            B_CRC_LO: state_next = load ? B_CRC_HI : B_CRC_LO;
            B_CRC_HI: state_next = load ? B_IDLE : B_CRC_HI;
            default:  state_next = B_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        pop             = (state_reg == B_IDLE) && !empty;
        idx_next        = idx_reg;
        crc_next        = crc_reg;
        frame_byte_next = frame_byte_reg;
        last_byte_next  = last_byte_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    idx_next = 3'd0;
                    crc_next = CRC_INIT;
                end
            end
            B_BODY:
            begin
                if (load)
                begin
                    idx_next        = idx_reg + 3'd1;
                    crc_next        = crc_feed(crc_reg, body_byte);
                    frame_byte_next = body_byte;
                    last_byte_next  = 1'b0;
                end
            end
            B_CRC_LO:
            begin
                if (load)
                begin
                    frame_byte_next = crc_reg[7:0];
                    last_byte_next  = 1'b0;
                end
            end
            B_CRC_HI:
            begin
                if (load)
                begin
                    frame_byte_next = crc_reg[15:8];
                    last_byte_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (pop)
            desc_reg <= pop_desc;
        idx_reg        <= idx_next;
        crc_reg        <= crc_next;
        frame_byte_reg <= frame_byte_next;
        last_byte_reg  <= last_byte_next;
    end

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == B_BODY && crc_reg == CRC_INIT && idx_reg == 3'd0))
        else $error("frame did not start with a fresh CRC");

endmodule

// ----- tb/tb_vfd_modbus_command_framer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vfd_modbus_command_framer
// Self-checking bench for the drive command framer.
// ----------------------------------------------------------------------------
// Spindle commands are fed through a valid/stall driver with random gaps.
// Frame bytes are taken by a monitor that stalls at random and checks each
// byte against frames predicted at command acceptance (address, function,
// length, data, CRC-16 low then high). The registers are rewritten over APB
// between phases while the block is idle, covering inverted limits, zero
// and maximum speeds, and address extremes. One long output hold forces
// the frame queue to fill and back-pressure the command input.
// ----------------------------------------------------------------------------
module tb_vfd_modbus_command_framer;
    import vmf_pkg::*;

    // One spindle command as driven on the input ports
    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  run_mode;
        logic [15:0] speed_rpm;
        logic [7:0]  override_pct;
        logic [2:0]  status_reg;
    } spindle_cmd_t;

    // One frame byte the block owes us
    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } frame_byte_exp_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            opcode = '0;
    logic [1:0]            run_mode = '0;
    logic [15:0]           speed_rpm = '0;
    logic [7:0]            override_pct = '0;
    logic [2:0]            status_reg = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            frame_byte;
    logic                  last_byte;

    // Predictor copy of registers and speed state
    logic [7:0]  cfg_addr = DEVICE_ADDRESS_RST;
    logic [15:0] cfg_min_rpm = MIN_RPM_RST;
    logic [15:0] cfg_max_rpm = MAX_RPM_RST;
    logic [15:0] drive_rpm_sent = 16'd0;

    spindle_cmd_t    pending_cmds[$];
    frame_byte_exp_t bytes_due[$];
    int              cmds_queued = 0;
    int              cmds_taken = 0;
    int              err_count = 0;

    // Idle control for both sides
    int   in_gap = 0;
    bit   in_quiet = 1'b0;
    int   out_wait = 0;
    bit   out_quiet = 1'b0;
    logic hold_out = 1'b0;

    // Last speed item, reused to hit the unchanged-speed case
    logic [15:0] prev_speed = 16'd0;
    logic [7:0]  prev_pct = 8'd100;

    vfd_modbus_command_framer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .run_mode     (run_mode),
        .speed_rpm    (speed_rpm),
        .override_pct (override_pct),
        .status_reg   (status_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte)
    );

    always #10 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Wait for one item or result; runs of zero waits come and go
    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 23) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    // Work out the frame bytes for one accepted command
    task automatic predict_frame_bytes(input spindle_cmd_t c);
        logic [7:0]      body [0:7];
        int              n;
        int unsigned     scaled;
        int unsigned     freq;
        logic [15:0]     rpm;
        logic [15:0]     crc;
        frame_byte_exp_t e;
        n = 0;
        body[0] = cfg_addr;
        case (c.opcode)
            OP_RUN_MODE:
            begin
                body[1] = FUNC_RUN_MODE;
                body[2] = LEN_RUN_MODE;
                case (c.run_mode)
                    RM_FORWARD: body[3] = RUN_CODE_FORWARD;
                    RM_REVERSE: body[3] = RUN_CODE_REVERSE;
                    default:    body[3] = RUN_CODE_STOP;
                endcase
                n = 4;
            end
            OP_SPEED:
            begin
                scaled = 32'(c.speed_rpm) * 32'(c.override_pct) / 100;
                // inverted limits win, then max, then raise nonzero to min
                if (cfg_min_rpm >= cfg_max_rpm || scaled >= 32'(cfg_max_rpm))
                    rpm = cfg_max_rpm;
                else if (scaled != 0 && scaled <= 32'(cfg_min_rpm))
                    rpm = cfg_min_rpm;
                else
                    rpm = scaled[15:0];
                if (rpm != drive_rpm_sent)
                begin
                    drive_rpm_sent = rpm;
                    freq = 32'(rpm) * 100 / 60;
                    body[1] = FUNC_SPEED;
                    body[2] = LEN_SPEED;
                    body[3] = freq[15:8];
                    body[4] = freq[7:0];
                    n = 5;
                end
            end
            OP_READ:
            begin
                body[1] = FUNC_READ;
                body[2] = LEN_READ;
                body[3] = {5'd0, c.status_reg};
                body[4] = 8'h00;
                body[5] = 8'h00;
                n = 6;
            end
            default: n = 0;
        endcase

        // Reflected CRC, one bit at a time
        crc = CRC_INIT;
        for (int i = 0; i < n; i++)
        begin
            e.data = body[i];
            e.is_last = 1'b0;
            bytes_due.push_back(e);
            for (int k = 0; k < 8; k++)
            begin
                if (crc[0] ^ body[i][k])
                    crc = (crc >> 1) ^ CRC_POLY;
                else
                    crc = crc >> 1;
            end
        end
        if (n != 0)
        begin
            e.data = crc[7:0];
            e.is_last = 1'b0;
            bytes_due.push_back(e);
            e.data = crc[15:8];
            e.is_last = 1'b1;
            bytes_due.push_back(e);
        end
    endtask

    // Command driver: predict on acceptance, then offer the next item
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        spindle_cmd_t c;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                c.opcode = opcode;
                c.run_mode = run_mode;
                c.speed_rpm = speed_rpm;
                c.override_pct = override_pct;
                c.status_reg = status_reg;
                predict_frame_bytes(c);
                cmds_taken = cmds_taken + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap != 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    c = pending_cmds.pop_front();
                    opcode <= c.opcode;
                    run_mode <= c.run_mode;
                    speed_rpm <= c.speed_rpm;
                    override_pct <= c.override_pct;
                    status_reg <= c.status_reg;
                    in_valid <= 1'b1;
                    in_gap <= draw_wait(in_quiet);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Frame byte monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin : byte_monitor
        frame_byte_exp_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected frame byte, expected none, got %h last %b",
                             $time, frame_byte, last_byte);
                    err_count = err_count + 1;
                end
                else
                begin
                    e = bytes_due.pop_front();
                    if (frame_byte !== e.data)
                    begin
                        $display("%0t: frame_byte mismatch, expected %h, got %h",
                                 $time, e.data, frame_byte);
                        err_count = err_count + 1;
                    end
                    if (last_byte !== e.is_last)
                    begin
                        $display("%0t: last_byte mismatch, expected %b, got %b",
                                 $time, e.is_last, last_byte);
                        err_count = err_count + 1;
                    end
                end
                out_wait = draw_wait(out_quiet);
            end
            else if (out_wait != 0)
            begin
                out_wait = out_wait - 1;
            end
            out_stall <= hold_out || (out_wait != 0);
        end
    end

    // Long output hold so the frame queue fills and stalls the input
    initial
    begin
        wait (cmds_taken >= 140);
        @(posedge clk);
        hold_out <= 1'b1;
        repeat (250) @(posedge clk);
        hold_out <= 1'b0;
    end

    // APB register write: setup, then access until pready
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DEVICE_ADDRESS: cfg_addr = val[7:0];
            REG_MIN_RPM:        cfg_min_rpm = val[15:0];
            REG_MAX_RPM:        cfg_max_rpm = val[15:0];
            default:            ;
        endcase
    endtask

    task automatic set_limits(input logic [7:0] addr, input logic [15:0] lo,
                              input logic [15:0] hi);
        apb_write(REG_DEVICE_ADDRESS, {24'd0, addr});
        apb_write(REG_MIN_RPM, {16'd0, lo});
        apb_write(REG_MAX_RPM, {16'd0, hi});
    endtask

    task automatic push_cmd(input logic [1:0] op, input logic [1:0] mode,
                            input logic [15:0] rpm, input logic [7:0] pct,
                            input logic [2:0] sreg);
        spindle_cmd_t c;
        c.opcode = op;
        c.run_mode = mode;
        c.speed_rpm = rpm;
        c.override_pct = pct;
        c.status_reg = sreg;
        pending_cmds.push_back(c);
        cmds_queued = cmds_queued + 1;
    endtask

    // Random command; unused fields carry random content too
    task automatic push_random_cmd();
        logic [1:0]  op;
        logic [15:0] rpm;
        logic [7:0]  pct;
        int          pick;
        int          kind;
        pick = $urandom_range(0, 99);
        rpm = 16'($urandom_range(0, 65535));
        pct = 8'($urandom_range(0, 255));
        if (pick < 5)
            op = 2'd3;
        else if (pick < 30)
            op = OP_RUN_MODE;
        else if (pick < 55)
            op = OP_READ;
        else
        begin
            op = OP_SPEED;
            kind = $urandom_range(0, 19);
            if (kind < 5)
            begin
                rpm = 16'($urandom_range(0, 40000));
                pct = 8'd100;
            end
            else if (kind < 8)
            begin
                rpm = prev_speed;
                pct = prev_pct;
            end
            else if (kind < 10)
            begin
                rpm = 16'($urandom_range(0, 200));
            end
            prev_speed = rpm;
            prev_pct = pct;
        end
        push_cmd(op, 2'($urandom_range(0, 3)), rpm, pct, 3'($urandom_range(0, 7)));
    endtask

    // Block until every item is taken and every byte has come out
    task automatic drain();
        @(negedge clk);
        while (cmds_taken != cmds_queued || bytes_due.size() != 0)
            @(negedge clk);
        // speed items that send nothing may still be in the front end
        repeat (24) @(negedge clk);
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            push_random_cmd();
        drain();
    endtask

    // Stimulus sequence
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Reset settings: every opcode and run mode, speed edge cases
        push_cmd(OP_RUN_MODE, 2'd0, 16'd0, 8'd0, 3'd0);
        push_cmd(OP_RUN_MODE, RM_FORWARD, 16'hFFFF, 8'hFF, 3'd7);
        push_cmd(OP_RUN_MODE, RM_REVERSE, 16'd0, 8'd0, 3'd0);
        push_cmd(OP_RUN_MODE, 2'd3, 16'd0, 8'd0, 3'd0);
        push_cmd(OP_READ, 2'd0, 16'd0, 8'd0, 3'd0);
        push_cmd(OP_READ, 2'd3, 16'hFFFF, 8'hFF, 3'd7);
        push_cmd(OP_READ, 2'd0, 16'd0, 8'd0, 3'd5);
        push_cmd(2'd3, 2'd1, 16'd1000, 8'd100, 3'd2);
        push_cmd(OP_SPEED, 2'd0, 16'd24000, 8'd100, 3'd0);
        push_cmd(OP_SPEED, 2'd0, 16'd24000, 8'd100, 3'd0);
        push_cmd(OP_SPEED, 2'd0, 16'hFFFF, 8'hFF, 3'd0);
        push_cmd(OP_SPEED, 2'd0, 16'd101, 8'd99, 3'd0);
        push_cmd(OP_SPEED, 2'd0, 16'd0, 8'hFF, 3'd0);
        push_cmd(OP_SPEED, 2'd0, 16'd12345, 8'd0, 3'd0);
        push_cmd(OP_SPEED, 2'd0, 16'd1000, 8'd150, 3'd0);
        drain();

        // Inverted limits with max at zero, top address
        set_limits(8'hFF, 16'd39321, 16'd0);
        push_cmd(OP_SPEED, 2'd0, 16'd5000, 8'd100, 3'd0);
        push_cmd(OP_SPEED, 2'd0, 16'd777, 8'd3, 3'd0);
        push_cmd(OP_RUN_MODE, RM_FORWARD, 16'd0, 8'd0, 3'd0);
        drain();

        // Raise to min, zero stays zero, full-scale frequency, address zero
        set_limits(8'h00, 16'd1000, 16'd39321);
        push_cmd(OP_SPEED, 2'd0, 16'd500, 8'd100, 3'd0);
        push_cmd(OP_SPEED, 2'd0, 16'd0, 8'd100, 3'd0);
        push_cmd(OP_SPEED, 2'd0, 16'd1, 8'd1, 3'd0);
        push_cmd(OP_SPEED, 2'd0, 16'hFFFF, 8'hFF, 3'd0);
        push_cmd(OP_SPEED, 2'd0, 16'd39321, 8'd100, 3'd0);
        push_cmd(OP_READ, 2'd0, 16'd0, 8'd0, 3'd3);
        drain();

        // Random phases over several limit settings
        set_limits(8'($urandom_range(0, 255)), 16'd0, 16'd39321);
        random_phase(85);
        set_limits(8'h5A, 16'd2000, 16'd24000);
        random_phase(85);
        set_limits(8'($urandom_range(0, 255)), 16'd5000, 16'd5000);
        random_phase(85);
        set_limits(8'($urandom_range(0, 255)), 16'd30000, 16'd10000);
        random_phase(85);
        set_limits(8'($urandom_range(0, 255)), 16'($urandom_range(0, 20000)),
                   16'($urandom_range(20000, 39321)));
        random_phase(85);

        repeat (30) @(negedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
